/* src/utf7dec_pkg.sv */
// Shared types, constants and a helper function for the UTF-7 byte decoder.
`timescale 1ns / 1ps
package utf7dec_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [3:0] MODE_DIRECT = 4'd0;
  localparam logic [3:0] MODE_OPEN   = 4'd1;
  localparam logic [3:0] MODE_B64_0  = 4'd2;
  localparam logic [3:0] MODE_B64_1  = 4'd3;
  localparam logic [3:0] MODE_B64_2  = 4'd4;
  localparam logic [3:0] MODE_B64_3  = 4'd5;
  localparam logic [3:0] MODE_B64_4  = 4'd6;
  localparam logic [3:0] MODE_B64_5  = 4'd7;
  localparam logic [3:0] MODE_B64_6  = 4'd8;
  localparam logic [3:0] MODE_B64_7  = 4'd9;

  localparam logic       REQ_DATA    = 1'b0;
  localparam logic       REQ_FLUSH   = 1'b1;

  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_SLASH    = 8'h2f;

  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
  localparam logic [11:0] PEND_BIAS   = 12'h040;

  typedef struct packed {
    logic        is_error;
    logic [20:0] code_point;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } qhead_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } b64_t;

  function automatic b64_t b64_decode(input logic [7:0] c);
    b64_t res;
    res.ok = 1'b1;
    res.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      res.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      res.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      res.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CH_PLUS) begin
      res.value = 6'd62;
    end else if (c == CH_SLASH) begin
      res.value = 6'd63;
    end else begin
      res.ok = 1'b0;
    end
    return res;
  endfunction

endpackage

/* src/utf7_byte_decoder_top.sv */
// Top level of the UTF-7 byte decoder: front end, result queue and output stage.
`timescale 1ns / 1ps
// The input channel takes one item per cycle while in_ready is high: a data
// byte (in_req_type low) or a flush request (in_req_type high). Each item
// causes zero, one or two results on the output channel, each a decoded code
// point or an error mark; out_last_of_run flags the final result of an item.
// The front end updates the decode mode and the bit buffer in the cycle the
// item is accepted and writes its results as one entry into a four-deep queue.
// The output stage loads the head entry into its output register when it is
// idle or its last result is being taken, and out_valid then rises for the
// first result of that item. While out_ready is high, the output port
// delivers one result per cycle; an item with two results presents them in
// turn, and items that produce no result never use the output.
// While the receiver holds out_ready low, results wait in the output register
// and the queue; in_ready drops only when the queue is full.
// Reset (rst_n low, synchronous) returns to direct mode with an empty bit
// buffer and discards all queued results.
module utf7_byte_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_error,
  output logic [20:0] out_code_point,
  output logic        out_last_of_run
);
  import utf7dec_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  qhead_t qhead;

  utf7dec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  utf7dec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .qhead      (qhead)
  );

  utf7dec_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qhead           (qhead),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_error    (out_is_error),
    .out_code_point  (out_code_point),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* src/utf7dec_front.sv */
// Front end: accepts items, tracks decode mode and bit buffer, forms result entries.
`timescale 1ns / 1ps
module utf7dec_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [7:0]           in_byte_value,
  input  logic                 q_full,
  output logic                 push,
  output utf7dec_pkg::entry_t  push_entry
);
  import utf7dec_pkg::*;

  typedef struct packed {
    logic v;
    res_t r;
  } emit_t;

  logic [3:0]  mode_r, mode_nxt;
  logic [27:0] buf_r, buf_nxt;

  logic        accept;
  logic [3:0]  mode_eff;
  b64_t        b64;
  logic [11:0] pend;
  logic        pending;
  logic        do_take;
  logic [15:0] unit;
  logic [15:0] rest;
  emit_t       ea, eb;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pend     = buf_r[27:16];
  assign pending  = |pend;
  assign b64      = b64_decode(in_byte_value);
  assign mode_eff = (mode_r > MODE_B64_7) ? MODE_DIRECT : mode_r;

  always_comb begin
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    ea       = '0;
    eb       = '0;
    do_take  = 1'b0;
    unit     = 16'd0;
    rest     = 16'd0;
    if (in_req_type == REQ_FLUSH) begin
      if (buf_r != 28'd0) begin
        ea.v = 1'b1;
        ea.r.is_error = 1'b1;
      end
      buf_nxt = 28'd0;
    end else if (mode_eff != MODE_DIRECT && !b64.ok) begin
      ea.v = (buf_r != 28'd0);
      ea.r.is_error = 1'b1;
      if (in_byte_value == CH_MINUS) begin
        eb.v = (mode_eff == MODE_OPEN);
        eb.r.code_point = {13'd0, CH_PLUS};
      end else if (!in_byte_value[7]) begin
        eb.v = 1'b1;
        eb.r.code_point = {13'd0, in_byte_value};
      end else begin
        eb.v = 1'b1;
        eb.r.is_error = 1'b1;
      end
      buf_nxt  = 28'd0;
      mode_nxt = MODE_DIRECT;
    end else begin
      case (mode_eff)
        MODE_DIRECT: begin
          if (in_byte_value == CH_PLUS) begin
            mode_nxt = MODE_OPEN;
          end else if (!in_byte_value[7]) begin
            eb.v = 1'b1;
            eb.r.code_point = {13'd0, in_byte_value};
          end else begin
            eb.v = 1'b1;
            eb.r.is_error = 1'b1;
          end
        end
        MODE_OPEN, MODE_B64_0: begin
          buf_nxt  = buf_r | ({22'd0, b64.value} << 10);
          mode_nxt = MODE_B64_1;
        end
        MODE_B64_1: begin
          buf_nxt  = buf_r | ({22'd0, b64.value} << 4);
          mode_nxt = MODE_B64_2;
        end
        MODE_B64_2: begin
          mode_nxt = MODE_B64_3;
          do_take  = 1'b1;
          unit     = buf_r[15:0] | {12'd0, b64.value[5:2]};
          rest     = {b64.value[1:0], 14'd0};
        end
        MODE_B64_3: begin
          buf_nxt  = buf_r | ({22'd0, b64.value} << 8);
          mode_nxt = MODE_B64_4;
        end
        MODE_B64_4: begin
          buf_nxt  = buf_r | ({22'd0, b64.value} << 2);
          mode_nxt = MODE_B64_5;
        end
        MODE_B64_5: begin
          mode_nxt = MODE_B64_6;
          do_take  = 1'b1;
          unit     = buf_r[15:0] | {14'd0, b64.value[5:4]};
          rest     = {b64.value[3:0], 12'd0};
        end
        MODE_B64_6: begin
          buf_nxt  = buf_r | ({22'd0, b64.value} << 6);
          mode_nxt = MODE_B64_7;
        end
        MODE_B64_7: begin
          mode_nxt = MODE_B64_0;
          do_take  = 1'b1;
          unit     = buf_r[15:0] | {10'd0, b64.value};
          rest     = 16'd0;
        end
        default: begin
        end
      endcase
      if (do_take) begin
        if (unit[15:10] == HI_SURR_TAG) begin
          ea.v = pending;
          ea.r.is_error = 1'b1;
          buf_nxt = {({2'd0, unit[9:0]} + PEND_BIAS), rest};
        end else if (unit[15:10] == LO_SURR_TAG) begin
          eb.v = 1'b1;
          if (pending) begin
            eb.r.code_point = {pend[10:0], unit[9:0]};
          end else begin
            eb.r.is_error = 1'b1;
          end
          buf_nxt = {12'd0, rest};
        end else begin
          ea.v = pending;
          ea.r.is_error = 1'b1;
          eb.v = 1'b1;
          eb.r.code_point = {5'd0, unit};
          buf_nxt = {12'd0, rest};
        end
      end
    end
  end

  always_comb begin
    push           = accept && (ea.v || eb.v);
    push_entry.two = ea.v && eb.v;
    push_entry.r0  = ea.v ? ea.r : eb.r;
    push_entry.r1  = eb.r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DIRECT;
      buf_r  <= 28'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
    end
  end

endmodule

/* src/utf7dec_queue.sv */
// Short queue of result entries between the front end and the output stage.
`timescale 1ns / 1ps
module utf7dec_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf7dec_pkg::entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output utf7dec_pkg::qhead_t  qhead
);
  import utf7dec_pkg::*;

  entry_t           mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign full        = (cnt_r == QCntW'(QDepth));
  assign qhead.valid = (cnt_r != '0);
  assign qhead.head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("Item pushed into a full queue.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !qhead.valid |-> !pop) else $error("Item popped from an empty queue.");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntW'(QDepth)) else $error("Queue count beyond its depth.");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == QCntW'(QDepth)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("Queue pointers disagree with the count.");

endmodule

/* src/utf7dec_back.sv */
// Output stage: walks each queued entry and presents its results one per cycle while out_ready is high.
`timescale 1ns / 1ps
module utf7dec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf7dec_pkg::qhead_t  qhead,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_error,
  output logic [20:0]          out_code_point,
  output logic                 out_last_of_run
);
  import utf7dec_pkg::*;

  entry_t ent_r;
  logic   valid_r;
  logic   sel_r;
  logic   at_last;
  res_t   cur;

  assign cur             = sel_r ? ent_r.r1 : ent_r.r0;
  assign at_last         = sel_r || !ent_r.two;
  assign out_valid       = valid_r;
  assign out_is_error    = cur.is_error;
  assign out_code_point  = cur.code_point;
  assign out_last_of_run = at_last;
  assign pop             = qhead.valid && (!valid_r || (out_ready && at_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= qhead.head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
      sel_r   <= 1'b0;
    end else if (valid_r && out_ready) begin
      if (at_last) begin
        valid_r <= 1'b0;
        sel_r   <= 1'b0;
      end else begin
        sel_r <= 1'b1;
      end
    end
  end

endmodule

/* verif/tb_utf7_byte_decoder_top.sv */
// Self-checking testbench for the UTF-7 byte decoder top level.
`timescale 1ns / 1ps
module tb_utf7_byte_decoder_top;
  import utf7dec_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int CalmTail    = 150;

  typedef struct packed {
    logic       req;
    logic [7:0] byte_val;
  } utf7_item_t;

  typedef struct packed {
    logic        is_error;
    logic [20:0] code_point;
    logic        last_of_run;
  } decoded_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        in_req_type   = REQ_DATA;
  logic [7:0]  in_byte_value = 8'h00;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_is_error;
  logic [20:0] out_code_point;
  logic        out_last_of_run;

  utf7_item_t  pending_items[$];
  decoded_t    expected_cps[$];
  decoded_t    step_cps[$];

  logic [3:0]  dec_mode  = MODE_DIRECT;
  logic [27:0] bits_held = '0;

  int err_cnt   = 0;
  int cycle_cnt = 0;
  int in_gap    = 0;
  int in_quiet  = 0;
  int out_gap   = 0;
  int out_quiet = 0;

  utf7_byte_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_error    (out_is_error),
    .out_code_point  (out_code_point),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  function automatic bit near_end();
    return pending_items.size() < CalmTail;
  endfunction

  // Returns {valid, value} for a modified-Base64 character.
  function automatic logic [6:0] b64_lookup(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return {1'b1, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7a) return {1'b1, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
    if (c == CH_PLUS) return {1'b1, 6'd62};
    if (c == CH_SLASH) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic add_cp(input logic err, input logic [20:0] cp);
    decoded_t r;
    if (step_cps.size() < 2) begin
      r.is_error    = err;
      r.code_point  = err ? 21'd0 : cp;
      r.last_of_run = 1'b0;
      step_cps.push_back(r);
    end
  endtask

  task automatic take_unit(input logic [15:0] unit, input logic [15:0] rest);
    logic        pend;
    logic [27:0] cp;
    pend = bits_held[27:16] != 12'd0;
    if (unit >= 16'hd800 && unit < 16'hdc00) begin
      if (pend) add_cp(1'b1, '0);
      bits_held = ((28'(unit[9:0]) << 16) + 28'h0400000) | 28'(rest);
    end else if (unit >= 16'hdc00 && unit < 16'he000) begin
      if (pend) begin
        cp = 28'(unit[9:0]) | ((bits_held & 28'hfff0000) >> 6);
        bits_held = 28'(rest);
        add_cp(1'b0, cp[20:0]);
      end else begin
        add_cp(1'b1, '0);
        bits_held = 28'(rest);
      end
    end else begin
      if (pend) add_cp(1'b1, '0);
      bits_held = 28'(rest);
      add_cp(1'b0, 21'(unit));
    end
  endtask

  task automatic decode_item(input logic req, input logic [7:0] c);
    logic [3:0] m;
    logic [6:0] lk;
    logic [5:0] n;
    logic       handled;
    decoded_t   r;
    step_cps.delete();
    n = '0;
    handled = 1'b0;
    if (req == REQ_FLUSH) begin
      if (bits_held != '0) begin
        bits_held = '0;
        add_cp(1'b1, '0);
      end
    end else begin
      m = (dec_mode > MODE_B64_7) ? MODE_DIRECT : dec_mode;
      lk = b64_lookup(c);
      if (m != MODE_DIRECT) begin
        if (!lk[6]) begin
          if (bits_held != '0) add_cp(1'b1, '0);
          if (c == CH_MINUS) begin
            if (m == MODE_OPEN) add_cp(1'b0, 21'(CH_PLUS));
          end else if (!c[7]) begin
            add_cp(1'b0, 21'(c));
          end else begin
            add_cp(1'b1, '0);
          end
          bits_held = '0;
          dec_mode = MODE_DIRECT;
          handled = 1'b1;
        end else begin
          n = lk[5:0];
        end
      end
      if (!handled) begin
        case (m)
          MODE_DIRECT: begin
            if (c == CH_PLUS) dec_mode = MODE_OPEN;
            else if (!c[7]) add_cp(1'b0, 21'(c));
            else add_cp(1'b1, '0);
          end
          MODE_OPEN, MODE_B64_0: begin
            bits_held |= 28'(n) << 10;
            dec_mode = MODE_B64_1;
          end
          MODE_B64_1: begin
            bits_held |= 28'(n) << 4;
            dec_mode = MODE_B64_2;
          end
          MODE_B64_2: begin
            dec_mode = MODE_B64_3;
            take_unit({12'd0, n[5:2]} | bits_held[15:0], {n[1:0], 14'd0});
          end
          MODE_B64_3: begin
            bits_held |= 28'(n) << 8;
            dec_mode = MODE_B64_4;
          end
          MODE_B64_4: begin
            bits_held |= 28'(n) << 2;
            dec_mode = MODE_B64_5;
          end
          MODE_B64_5: begin
            dec_mode = MODE_B64_6;
            take_unit({14'd0, n[5:4]} | bits_held[15:0], {n[3:0], 12'd0});
          end
          MODE_B64_6: begin
            bits_held |= 28'(n) << 6;
            dec_mode = MODE_B64_7;
          end
          MODE_B64_7: begin
            dec_mode = MODE_B64_0;
            take_unit({10'd0, n} | bits_held[15:0], 16'd0);
          end
          default: ;
        endcase
      end
    end
    if (step_cps.size() > 0) begin
      r = step_cps.pop_back();
      r.last_of_run = 1'b1;
      step_cps.push_back(r);
    end
    foreach (step_cps[i]) expected_cps.push_back(step_cps[i]);
  endtask

  task automatic push_item(input logic req, input logic [7:0] b);
    utf7_item_t it;
    it.req = req;
    it.byte_val = b;
    pending_items.push_back(it);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_item(REQ_DATA, s[i]);
  endtask

  // Encodes random UTF-16 units as one section, with an occasional flush,
  // stray padding bits and one of several section endings.
  task automatic push_section(input int nunits);
    logic [15:0] units[$];
    logic        bitq[$];
    logic [15:0] u;
    logic [5:0]  g;
    logic [7:0]  t;
    push_item(REQ_DATA, CH_PLUS);
    for (int i = 0; i < nunits; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          u = 16'($urandom);
          while (u >= 16'hd800 && u < 16'he000) u = 16'($urandom);
          units.push_back(u);
        end
        4: units.push_back(16'($urandom_range(0, 127)));
        5, 6: begin
          units.push_back(16'hd800 | 16'($urandom_range(0, 1023)));
          units.push_back(16'hdc00 | 16'($urandom_range(0, 1023)));
        end
        7: units.push_back(16'hd800 | 16'($urandom_range(0, 1023)));
        8: units.push_back(16'hdc00 | 16'($urandom_range(0, 1023)));
        default: begin
          case ($urandom_range(0, 6))
            0: units.push_back(16'h0000);
            1: units.push_back(16'hffff);
            2: units.push_back(16'hd800);
            3: units.push_back(16'hdbff);
            4: units.push_back(16'hdc00);
            5: units.push_back(16'hdfff);
            default: units.push_back(16'he000);
          endcase
        end
      endcase
    end
    foreach (units[k]) begin
      for (int b = 15; b >= 0; b--) bitq.push_back(units[k][b]);
    end
    while (bitq.size() % 6 != 0) begin
      bitq.push_back(($urandom_range(0, 7) == 0) ? 1'($urandom) : 1'b0);
    end
    while (bitq.size() >= 6) begin
      for (int b = 5; b >= 0; b--) g[b] = bitq.pop_front();
      if ($urandom_range(0, 29) == 0) push_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
      push_item(REQ_DATA, b64_char(g));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: push_item(REQ_DATA, CH_MINUS);
      6, 7: begin
        t = 8'($urandom_range(0, 127));
        while (b64_lookup(t) >= 7'h40) t = 8'($urandom_range(0, 127));
        push_item(REQ_DATA, t);
      end
      8: push_item(REQ_DATA, 8'($urandom_range(128, 255)));
      default: push_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
    endcase
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("tb_utf7_byte_decoder_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic       nv;
    utf7_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        decode_item(in_req_type, in_byte_value);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          if (!near_end() && in_quiet == 0 && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 15);
            in_quiet = $urandom_range(0, 40);
          end else begin
            nxt = pending_items.pop_front();
            in_req_type <= nxt.req;
            in_byte_value <= nxt.byte_val;
            nv = 1'b1;
            if (in_quiet > 0) in_quiet--;
          end
        end
      end
      in_valid <= nv;
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    logic     nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cps.size() == 0) begin
          $error("unexpected result: is_error %0b code_point %0h", out_is_error,
                 out_code_point);
          err_cnt++;
        end else begin
          want = expected_cps.pop_front();
          if (out_is_error !== want.is_error) begin
            $error("is_error: expected %0b, actual %0b", want.is_error, out_is_error);
            err_cnt++;
          end
          if (out_code_point !== want.code_point) begin
            $error("code_point: expected %0h, actual %0h", want.code_point, out_code_point);
            err_cnt++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                   out_last_of_run);
            err_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        nr = 1'b0;
      end else if (!near_end() && out_quiet == 0 && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_quiet = $urandom_range(0, 60);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if (out_quiet > 0) out_quiet--;
      end
      out_ready <= nr;
    end
  end

  initial begin
    int         target;
    logic [7:0] ch;
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'h7f);
    push_item(REQ_DATA, 8'h80);
    push_item(REQ_FLUSH, 8'hff);
    push_text("+-");
    push_text("+AGF");
    push_item(REQ_DATA, 8'hff);
    push_text("+2D3eAA-");
    push_text("+3AB");
    push_item(REQ_FLUSH, 8'h00);
    push_text(".");
    target = pending_items.size() + 1100;
    while (pending_items.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_section($urandom_range(0, 6));
        6, 7: begin
          repeat ($urandom_range(1, 8)) begin
            ch = 8'($urandom_range(0, 127));
            if (ch == CH_PLUS) ch = CH_MINUS;
            push_item(REQ_DATA, ch);
          end
        end
        8: begin
          repeat ($urandom_range(1, 6)) begin
            push_item(($urandom_range(0, 9) == 0) ? REQ_FLUSH : REQ_DATA,
                      8'($urandom_range(0, 255)));
          end
        end
        default: push_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
      endcase
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_cps.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (expected_cps.size() != 0) begin
      $error("%0d expected results never arrived", expected_cps.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_utf7_byte_decoder_top: clean");
    end else begin
      $display("tb_utf7_byte_decoder_top: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/utf7dec_pkg.sv
src/utf7dec_front.sv
src/utf7dec_queue.sv
src/utf7dec_back.sv
src/utf7_byte_decoder_top.sv
verif/tb_utf7_byte_decoder_top.sv
